>>> rtl/core/art_pkg.sv
package art_pkg;

  // Counter width; all ones at this width is the overflow point.
  localparam int CNT_W = 32;

  localparam int DATA_W = 32;
  localparam int IDX_W = 5;
  localparam int FUNC_W = 2;
  localparam int PSC_W = 8;
  localparam int SEL_W = 3;

  // Packed widths of the stream payloads, rounded up to whole bytes.
  localparam int IN_TDATA_W = ((IDX_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam func_t FUNC_TICK = 2'd0;
  localparam func_t FUNC_READ = 2'd1;
  localparam func_t FUNC_WRITE = 2'd2;

  localparam idx_t REG_RAW = 5'd9;
  localparam idx_t REG_STATUS = 5'd10;
  localparam idx_t REG_SET = 5'd11;
  localparam idx_t REG_CLR = 5'd12;
  localparam idx_t REG_CTRL = 5'd14;
  localparam idx_t REG_COUNT = 5'd15;
  localparam idx_t REG_LOAD = 5'd16;
  localparam idx_t REG_TRIGGER = 5'd17;

  // Bit position of the overflow flag in the status and enable registers.
  localparam int OVF_BIT = 1;

  // Control register bit positions.
  localparam int CTRL_START = 0;
  localparam int CTRL_AUTORELOAD = 1;
  localparam int CTRL_SEL_LO = 2;
  localparam int CTRL_PSC_EN = 5;

  typedef struct packed {
    func_t func;
    idx_t reg_index;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic irq_line;
  } result_t;

endpackage

>>> rtl/core/auto_reload_timer_peripheral.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: func; tdata: reg_index, write_data
// m_*      out  m_tvalid/m_tready  tdata: read_data, irq_line
//
// Every item gives exactly one result. An item waits in the input register
// and is resolved against the timer state on its way into the output
// register; one item is taken every cycle unless a stall holds the input.
// The output register frees itself in the cycle it is taken, so a stall only
// holds the input side when both registers are full.
// Reset is synchronous and clears all timer state and both valid flags.
module auto_reload_timer_peripheral (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [art_pkg::IN_TDATA_W-1:0]      s_tdata,   // reg_index, write_data
  input  logic [art_pkg::FUNC_W-1:0]          s_tuser,   // func
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [art_pkg::OUT_TDATA_W-1:0]     m_tdata    // read_data, irq_line
);

  logic in_valid;
  art_pkg::item_t in_item;
  art_pkg::result_t res;
  art_pkg::result_t out_res;
  logic adv;
  logic fire;

  assign adv = !m_tvalid || m_tready;
  assign fire = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func <= s_tuser;
      in_item.reg_index <= s_tdata[art_pkg::IDX_W-1:0];
      in_item.write_data <= s_tdata[art_pkg::IDX_W +: art_pkg::DATA_W];
    end
  end

  art_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .en     (fire),
    .item   (in_item),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[art_pkg::DATA_W-1:0] = out_res.read_data;
    m_tdata[art_pkg::DATA_W] = out_res.irq_line;
  end

endmodule

>>> rtl/core/art_timer.sv
module art_timer (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  art_pkg::item_t   item,
  output art_pkg::result_t result
);

  art_pkg::cnt_t count_value;
  art_pkg::cnt_t count_value_next;
  art_pkg::cnt_t reload_value;
  art_pkg::cnt_t reload_value_next;
  logic run_enable;
  logic run_enable_next;
  logic autoreload_enable;
  logic autoreload_enable_next;
  logic [art_pkg::SEL_W-1:0] prescale_select;
  logic [art_pkg::SEL_W-1:0] prescale_select_next;
  logic prescale_enable;
  logic prescale_enable_next;
  logic [art_pkg::PSC_W-1:0] prescale_count;
  logic [art_pkg::PSC_W-1:0] prescale_count_next;
  logic overflow_raw;
  logic overflow_raw_next;
  logic overflow_irq_enable;
  logic overflow_irq_enable_next;

  logic [art_pkg::PSC_W:0] psc_inc;
  logic [art_pkg::PSC_W:0] psc_div;
  logic step;
  logic [art_pkg::DATA_W-1:0] read_value;
  logic is_tick;
  logic wr_ovf;

  localparam art_pkg::cnt_t CNT_MAX = {art_pkg::CNT_W{1'b1}};

  assign is_tick = (item.func == art_pkg::FUNC_TICK);
  assign wr_ovf = item.write_data[art_pkg::OVF_BIT];
  assign psc_inc = {1'b0, prescale_count} + 1'b1;
  assign psc_div = (art_pkg::PSC_W + 1)'(1) << ({1'b0, prescale_select} + 4'd1);

  always_comb begin
    count_value_next = count_value;
    reload_value_next = reload_value;
    run_enable_next = run_enable;
    autoreload_enable_next = autoreload_enable;
    prescale_select_next = prescale_select;
    prescale_enable_next = prescale_enable;
    prescale_count_next = prescale_count;
    overflow_raw_next = overflow_raw;
    overflow_irq_enable_next = overflow_irq_enable;
    step = 1'b0;

    if (is_tick && run_enable) begin
      if (prescale_enable) begin
        if (psc_inc >= psc_div) begin
          prescale_count_next = '0;
          step = 1'b1;
        end else begin
          prescale_count_next = psc_inc[art_pkg::PSC_W-1:0];
        end
      end else begin
        prescale_count_next = '0;
        step = 1'b1;
      end
    end

    if (step) begin
      if (count_value == CNT_MAX) begin
        count_value_next = reload_value;
        overflow_raw_next = 1'b1;
        if (!autoreload_enable) begin
          run_enable_next = 1'b0;
        end
      end else begin
        count_value_next = count_value + 1'b1;
      end
    end

    if (item.func == art_pkg::FUNC_WRITE) begin
      unique case (item.reg_index)
        art_pkg::REG_RAW: begin
          if (wr_ovf) overflow_raw_next = 1'b1;
        end
        art_pkg::REG_STATUS: begin
          if (wr_ovf) overflow_raw_next = 1'b0;
        end
        art_pkg::REG_SET: begin
          if (wr_ovf) overflow_irq_enable_next = 1'b1;
        end
        art_pkg::REG_CLR: begin
          if (wr_ovf) overflow_irq_enable_next = 1'b0;
        end
        art_pkg::REG_CTRL: begin
          run_enable_next = item.write_data[art_pkg::CTRL_START];
          autoreload_enable_next = item.write_data[art_pkg::CTRL_AUTORELOAD];
          prescale_select_next =
            item.write_data[art_pkg::CTRL_SEL_LO +: art_pkg::SEL_W];
          prescale_enable_next = item.write_data[art_pkg::CTRL_PSC_EN];
          if (!item.write_data[art_pkg::CTRL_PSC_EN]) prescale_count_next = '0;
        end
        art_pkg::REG_COUNT: begin
          count_value_next = item.write_data[art_pkg::CNT_W-1:0];
          prescale_count_next = '0;
        end
        art_pkg::REG_LOAD: begin
          reload_value_next = item.write_data[art_pkg::CNT_W-1:0];
        end
        art_pkg::REG_TRIGGER: begin
          count_value_next = reload_value;
          prescale_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    read_value = '0;
    if (item.func == art_pkg::FUNC_READ) begin
      unique case (item.reg_index)
        art_pkg::REG_RAW: read_value[art_pkg::OVF_BIT] = overflow_raw;
        art_pkg::REG_STATUS:
          read_value[art_pkg::OVF_BIT] = overflow_raw & overflow_irq_enable;
        art_pkg::REG_SET, art_pkg::REG_CLR:
          read_value[art_pkg::OVF_BIT] = overflow_irq_enable;
        art_pkg::REG_CTRL: begin
          read_value[art_pkg::CTRL_START] = run_enable;
          read_value[art_pkg::CTRL_AUTORELOAD] = autoreload_enable;
          read_value[art_pkg::CTRL_SEL_LO +: art_pkg::SEL_W] = prescale_select;
          read_value[art_pkg::CTRL_PSC_EN] = prescale_enable;
        end
        art_pkg::REG_COUNT: read_value = art_pkg::DATA_W'(count_value);
        art_pkg::REG_LOAD: read_value = art_pkg::DATA_W'(reload_value);
        default: read_value = '0;
      endcase
    end
  end

  // The interrupt level reflects the state as it stands after this item.
  assign result.read_data = read_value;
  assign result.irq_line = overflow_raw_next & overflow_irq_enable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value <= '0;
      reload_value <= '0;
      run_enable <= 1'b0;
      autoreload_enable <= 1'b0;
      prescale_select <= '0;
      prescale_enable <= 1'b0;
      prescale_count <= '0;
      overflow_raw <= 1'b0;
      overflow_irq_enable <= 1'b0;
    end else if (en) begin
      count_value <= count_value_next;
      reload_value <= reload_value_next;
      run_enable <= run_enable_next;
      autoreload_enable <= autoreload_enable_next;
      prescale_select <= prescale_select_next;
      prescale_enable <= prescale_enable_next;
      prescale_count <= prescale_count_next;
      overflow_raw <= overflow_raw_next;
      overflow_irq_enable <= overflow_irq_enable_next;
    end
  end

  a_psc_idle_zero: assert property (@(posedge clk) disable iff (rst)
    !prescale_enable |-> prescale_count == '0)
    else $error("prescale count nonzero while prescaler is off");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (en && is_tick && !run_enable) |=> count_value == $past(count_value))
    else $error("counter moved on a tick while stopped");

  a_wrap_reload: assert property (@(posedge clk) disable iff (rst)
    (en && is_tick && run_enable && !prescale_enable && count_value == CNT_MAX)
    |=> (overflow_raw && count_value == $past(reload_value)))
    else $error("wrap did not reload and flag overflow");

endmodule

>>> verif/auto_reload_timer_peripheral_tb.sv
`timescale 1ns / 100ps

module auto_reload_timer_peripheral_tb;

  // The one function code that the block leaves undefined.
  localparam art_pkg::func_t FUNC_UNUSED = 2'd3;
  // A register index with nothing behind it.
  localparam art_pkg::idx_t REG_UNMAPPED = 5'd31;
  localparam int RANDOM_ITEMS = 1700;

  // Shadow copy of the timer state. It works out the result of every accepted
  // item and keeps the results still to come, oldest first.
  class timer_shadow;
    art_pkg::cnt_t count_q;
    art_pkg::cnt_t reload_q;
    bit running;
    bit autoreload;
    bit psc_en;
    bit ovf_raw;
    bit ovf_ie;
    logic [art_pkg::SEL_W-1:0] psc_sel;
    logic [art_pkg::PSC_W-1:0] psc_cnt;
    art_pkg::result_t expected_results[$];
    int mismatches;

    function new();
      count_q = '0;
      reload_q = '0;
      running = 0;
      autoreload = 0;
      psc_en = 0;
      ovf_raw = 0;
      ovf_ie = 0;
      psc_sel = '0;
      psc_cnt = '0;
      mismatches = 0;
    endfunction

    // One count step; past all ones the counter reloads and flags overflow.
    function void step_counter();
      if (count_q == '1) begin
        count_q = reload_q;
        ovf_raw = 1;
        if (!autoreload) running = 0;
      end else begin
        count_q = count_q + 1'b1;
      end
    endfunction

    function void note_item(art_pkg::func_t f, art_pkg::idx_t idx,
                            logic [art_pkg::DATA_W-1:0] d);
      art_pkg::result_t res;
      logic [art_pkg::PSC_W:0] nxt;
      res.read_data = '0;
      case (f)
        art_pkg::FUNC_TICK: begin
          if (running) begin
            if (psc_en) begin
              nxt = {1'b0, psc_cnt} + 1'b1;
              if (int'(nxt) >= (1 << (int'(psc_sel) + 1))) begin
                psc_cnt = '0;
                step_counter();
              end else begin
                psc_cnt = nxt[art_pkg::PSC_W-1:0];
              end
            end else begin
              psc_cnt = '0;
              step_counter();
            end
          end
        end
        art_pkg::FUNC_READ: begin
          case (idx)
            art_pkg::REG_RAW: res.read_data[art_pkg::OVF_BIT] = ovf_raw;
            art_pkg::REG_STATUS: res.read_data[art_pkg::OVF_BIT] = ovf_raw & ovf_ie;
            art_pkg::REG_SET, art_pkg::REG_CLR: res.read_data[art_pkg::OVF_BIT] = ovf_ie;
            art_pkg::REG_CTRL: begin
              res.read_data[art_pkg::CTRL_START] = running;
              res.read_data[art_pkg::CTRL_AUTORELOAD] = autoreload;
              res.read_data[art_pkg::CTRL_SEL_LO +: art_pkg::SEL_W] = psc_sel;
              res.read_data[art_pkg::CTRL_PSC_EN] = psc_en;
            end
            art_pkg::REG_COUNT: res.read_data = art_pkg::DATA_W'(count_q);
            art_pkg::REG_LOAD: res.read_data = art_pkg::DATA_W'(reload_q);
            default: ;
          endcase
        end
        art_pkg::FUNC_WRITE: begin
          case (idx)
            art_pkg::REG_RAW: if (d[art_pkg::OVF_BIT]) ovf_raw = 1;
            art_pkg::REG_STATUS: if (d[art_pkg::OVF_BIT]) ovf_raw = 0;
            art_pkg::REG_SET: if (d[art_pkg::OVF_BIT]) ovf_ie = 1;
            art_pkg::REG_CLR: if (d[art_pkg::OVF_BIT]) ovf_ie = 0;
            art_pkg::REG_CTRL: begin
              running = d[art_pkg::CTRL_START];
              autoreload = d[art_pkg::CTRL_AUTORELOAD];
              psc_sel = d[art_pkg::CTRL_SEL_LO +: art_pkg::SEL_W];
              psc_en = d[art_pkg::CTRL_PSC_EN];
              if (!psc_en) psc_cnt = '0;
            end
            art_pkg::REG_COUNT: begin
              count_q = art_pkg::cnt_t'(d);
              psc_cnt = '0;
            end
            art_pkg::REG_LOAD: reload_q = art_pkg::cnt_t'(d);
            art_pkg::REG_TRIGGER: begin
              count_q = reload_q;
              psc_cnt = '0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
      res.irq_line = ovf_raw & ovf_ie;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [art_pkg::OUT_TDATA_W-1:0] tdata);
      art_pkg::result_t want;
      logic [art_pkg::DATA_W-1:0] got_rd;
      logic got_irq;
      got_rd = tdata[art_pkg::DATA_W-1:0];
      got_irq = tdata[art_pkg::DATA_W];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: read_data %h irq_line %b", got_rd, got_irq);
        return;
      end
      want = expected_results.pop_front();
      if (got_rd !== want.read_data || got_irq !== want.irq_line) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: read_data exp %h got %h, irq_line exp %b got %b",
                   $realtime, want.read_data, got_rd, want.irq_line, got_irq);
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [art_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic [art_pkg::FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [art_pkg::OUT_TDATA_W-1:0] m_tdata;

  timer_shadow shadow = new();
  int items_sent = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_ready = 1'b0;

  auto_reload_timer_peripheral dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver stalls: stretches of full rate, coin-flip readiness, and long holds.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(16, 96);
    end
    mode_left--;
    case (rx_mode)
      0: m_tready = 1'b1;
      1: m_tready = 1'($urandom_range(0, 1));
      default: begin
        if (hold_left == 0) begin
          hold_ready = !hold_ready;
          hold_left = hold_ready ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        hold_left--;
        m_tready = hold_ready;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready)
      shadow.check_result(m_tdata);
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance.
  task automatic send_item(input art_pkg::func_t f, input art_pkg::idx_t idx,
                           input logic [art_pkg::DATA_W-1:0] d);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
    end
    s_tvalid = 1'b1;
    s_tuser = f;
    s_tdata = art_pkg::IN_TDATA_W'({d, idx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.note_item(f, idx, d);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (shadow.expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic logic [art_pkg::DATA_W-1:0] near_top(int span);
    return art_pkg::DATA_W'(art_pkg::cnt_t'('1) - art_pkg::cnt_t'($urandom_range(0, span)));
  endfunction

  // Load, counter near the top, sometimes the interrupt enable, control, then
  // mostly ticks with register traffic mixed in so that overflows and reloads happen often.
  task automatic timer_run();
    art_pkg::idx_t modeled [8];
    bit psc;
    int n;
    logic [art_pkg::DATA_W-1:0] ctrl;
    logic [art_pkg::DATA_W-1:0] val;
    art_pkg::idx_t idx;
    art_pkg::func_t f;
    modeled = '{art_pkg::REG_RAW, art_pkg::REG_STATUS, art_pkg::REG_SET, art_pkg::REG_CLR,
                art_pkg::REG_CTRL, art_pkg::REG_COUNT, art_pkg::REG_LOAD,
                art_pkg::REG_TRIGGER};
    psc = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: val = '0;
      1: val = '1;
      2: val = $urandom;
      default: val = near_top(8);
    endcase
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_LOAD, val);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_COUNT, near_top(psc ? 2 : 24));
    if ($urandom_range(0, 1))
      send_item(art_pkg::FUNC_WRITE, art_pkg::REG_SET, $urandom | (1 << art_pkg::OVF_BIT));
    ctrl = $urandom;
    ctrl[art_pkg::CTRL_START] = ($urandom_range(0, 9) != 0);
    ctrl[art_pkg::CTRL_PSC_EN] = psc;
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_CTRL, ctrl);
    n = (psc && $urandom_range(0, 3) == 0) ? 300 : $urandom_range(4, 40);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) begin
        send_item(art_pkg::FUNC_TICK, art_pkg::idx_t'($urandom), $urandom);
      end else begin
        f = $urandom_range(0, 1) ? art_pkg::FUNC_READ : art_pkg::FUNC_WRITE;
        idx = modeled[$urandom_range(0, 7)];
        val = $urandom;
        if (f == art_pkg::FUNC_WRITE && idx == art_pkg::REG_COUNT) val = near_top(16);
        send_item(f, idx, val);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values, a stopped timer, then an overflow without autoreload.
    send_item(art_pkg::FUNC_READ, art_pkg::REG_CTRL, '0);
    send_item(art_pkg::FUNC_TICK, art_pkg::REG_COUNT, '1);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_COUNT, '0);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_LOAD, 32'h1234_5678);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_COUNT, 32'hffff_fffe);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_SET, 32'h0000_0002);
    // Control bits above the prescale enable are ignored.
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_CTRL, 32'hffff_ffc1);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_CTRL, '0);
    repeat (3) send_item(art_pkg::FUNC_TICK, '0, '0);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_STATUS, '0);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_RAW, '0);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_STATUS, 32'h0000_0002);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_RAW, 32'h0000_0002);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_CLR, '1);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_SET, '0);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_TRIGGER, '0);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_TRIGGER, '0);
    // Slowest prescale with autoreload, then prescaler off.
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_CTRL, 32'h0000_003f);
    send_item(art_pkg::FUNC_TICK, '0, '0);
    send_item(art_pkg::FUNC_WRITE, art_pkg::REG_CTRL, 32'h0000_0003);
    send_item(art_pkg::FUNC_READ, art_pkg::REG_COUNT, '0);
    // Unmodelled registers and the unused function code.
    send_item(art_pkg::FUNC_WRITE, REG_UNMAPPED, '1);
    send_item(art_pkg::FUNC_READ, '0, '0);
    send_item(FUNC_UNUSED, art_pkg::REG_CTRL, '0);
    drain();

    while (items_sent < RANDOM_ITEMS + 25) begin
      if ($urandom_range(0, 19) == 0) drain();
      if ($urandom_range(0, 9) < 7) begin
        timer_run();
      end else begin
        repeat ($urandom_range(3, 12))
          send_item(art_pkg::func_t'($urandom), art_pkg::idx_t'($urandom), $urandom);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_results.size() == 0) begin
      $display("PASS auto_reload_timer_peripheral");
    end else begin
      $display("FAIL auto_reload_timer_peripheral");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL auto_reload_timer_peripheral");
    $finish;
  end

endmodule
